### rtl/bse_pkg.sv
// Package of the BMP stream encoder: payload structs, the command passed from
// the front to the back, and the fixed header constants. No dependencies.
package bse_pkg;

  localparam int unsigned SizeW    = 15;
  localparam int unsigned MaxSide  = 32766;
  localparam int unsigned HdrBytes = 14 + 40;
  localparam int unsigned InfoSize = 40;
  localparam int unsigned BitCount = 24;
  localparam logic [15:0] BmpMagic = 16'h4d42;

  // Configuration register indexes.
  localparam logic CfgImageWidth  = 1'b0;
  localparam logic CfgImageHeight = 1'b1;

  typedef struct packed {
    logic signed [15:0] red;
    logic signed [15:0] green;
    logic signed [15:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       frame_done;
  } result_t;

  // One classified pixel, as the back part needs it to emit its bytes.
  typedef struct packed {
    logic             hdr;
    logic             frame_end;
    logic [1:0]       pad;
    logic [7:0]       byte_b;
    logic [7:0]       byte_g;
    logic [7:0]       byte_r;
    logic [SizeW-1:0] width;
    logic [SizeW-1:0] height;
    logic [31:0]      file_size;
  } cmd_t;

endpackage

### rtl/bse_front.sv
// Front part of the BMP stream encoder: configuration registers, row and
// column tracking, channel conversion and file size. Depends on bse_pkg.
module bse_front import bse_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [SizeW-1:0] cfg_data_i,
  input  logic             accept_i,
  input  pixel_t           pixel_i,
  output cmd_t             cmd_o
);

  logic [SizeW-1:0] width_q, height_q;
  logic [SizeW-1:0] col_q, col_d, row_q, row_d;
  logic             hdr_sent_q, hdr_sent_d;
  logic [SizeW-1:0] w_eff, h_eff;
  logic [16:0]      row_bytes;
  logic [31:0]      fsize;
  logic             row_end, frame_end;

  function automatic logic [SizeW-1:0] eff_size(input logic [SizeW-1:0] v);
    logic [SizeW-1:0] r;
    if (v == '0) begin
      r = SizeW'(1);
    end else if (v > SizeW'(MaxSide)) begin
      r = SizeW'(MaxSide);
    end else begin
      r = v;
    end
    return r;
  endfunction

  // Zero or negative maps to 0, one or more saturates, otherwise drop 4 bits.
  function automatic logic [7:0] chan_byte(input logic signed [15:0] v);
    logic [7:0] r;
    if (v[15] || v == '0) begin
      r = 8'd0;
    end else if (v >= 16'sd4096) begin
      r = 8'hff;
    end else begin
      r = v[11:4];
    end
    return r;
  endfunction

  assign w_eff     = eff_size(width_q);
  assign h_eff     = eff_size(height_q);
  assign row_bytes = 17'(w_eff) * 17'd3 + 17'(w_eff[1:0]);
  assign fsize     = 32'(row_bytes) * 32'(h_eff) + 32'(HdrBytes);
  assign row_end   = (col_q >= w_eff - SizeW'(1));
  assign frame_end = row_end && (row_q >= h_eff - SizeW'(1));

  always_comb begin
    cmd_o.hdr       = !hdr_sent_q;
    cmd_o.frame_end = frame_end;
    // Padding to a multiple of four bytes equals the width modulo four.
    cmd_o.pad       = row_end ? w_eff[1:0] : 2'd0;
    cmd_o.byte_b    = chan_byte(pixel_i.blue);
    cmd_o.byte_g    = chan_byte(pixel_i.green);
    cmd_o.byte_r    = chan_byte(pixel_i.red);
    cmd_o.width     = w_eff;
    cmd_o.height    = h_eff;
    cmd_o.file_size = fsize;
  end

  always_comb begin
    col_d      = col_q;
    row_d      = row_q;
    hdr_sent_d = hdr_sent_q;
    if (accept_i) begin
      hdr_sent_d = !frame_end;
      if (row_end) begin
        col_d = '0;
        row_d = frame_end ? '0 : row_q + SizeW'(1);
      end else begin
        col_d = col_q + SizeW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q    <= SizeW'(1);
      height_q   <= SizeW'(1);
      col_q      <= '0;
      row_q      <= '0;
      hdr_sent_q <= 1'b0;
    end else begin
      if (cfg_we_i && cfg_idx_i == CfgImageWidth) begin
        width_q <= cfg_data_i;
      end
      if (cfg_we_i && cfg_idx_i == CfgImageHeight) begin
        height_q <= cfg_data_i;
      end
      col_q      <= col_d;
      row_q      <= row_d;
      hdr_sent_q <= hdr_sent_d;
    end
  end

endmodule

### rtl/bse_queue.sv
// Short command queue between the front and back parts of the BMP stream
// encoder. Depends on bse_pkg.
module bse_queue import bse_pkg::*; #(
  parameter int unsigned Depth = 4
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_i,
  input  cmd_t wr_data_i,
  output logic full_o,
  input  logic rd_i,
  output cmd_t rd_data_o,
  output logic valid_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    logic [PtrW-1:0] r;
    if (p == PtrW'(Depth - 1)) begin
      r = '0;
    end else begin
      r = p + PtrW'(1);
    end
    return r;
  endfunction

  assign full_o    = (count_q == CntW'(Depth));
  assign valid_o   = (count_q != '0);
  assign rd_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (wr_i) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (rd_i) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      if (wr_i && !rd_i) begin
        count_q <= count_q + CntW'(1);
      end else if (rd_i && !wr_i) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

endmodule

### rtl/bse_back.sv
// Back part of the BMP stream encoder: walks each command byte by byte
// (header, pixel, padding) into the output register. Depends on bse_pkg.
module bse_back import bse_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    cmd_valid_i,
  input  cmd_t    cmd_i,
  output logic    cmd_pop_o,
  output logic    empty_o,
  input  logic    pop_i,
  output result_t result_o
);

  logic [5:0] pos_q;
  logic       started_q;
  logic [5:0] pos, last_pos;
  logic       advance, is_last;
  logic [7:0] cur_byte;
  result_t    out_q;
  logic       out_valid_q;

  function automatic logic [7:0] word_byte(input logic [31:0] w, input logic [1:0] sel);
    logic [31:0] s;
    s = w >> {sel, 3'b000};
    return s[7:0];
  endfunction

  // Header byte at offset p. Every 32-bit field starts at an offset of two
  // modulo four, so the byte lane is p minus two.
  function automatic logic [7:0] hdr_byte(input logic [5:0] p, input cmd_t c);
    logic [1:0]  sel;
    logic [31:0] neg_h;
    logic [7:0]  r;
    sel   = p[1:0] - 2'd2;
    neg_h = 32'd0 - 32'(c.height);
    case (p)
      6'd0:                      r = BmpMagic[7:0];
      6'd1:                      r = BmpMagic[15:8];
      6'd2, 6'd3, 6'd4, 6'd5:    r = word_byte(c.file_size, sel);
      6'd10, 6'd11, 6'd12, 6'd13: r = word_byte(32'(HdrBytes), sel);
      6'd14, 6'd15, 6'd16, 6'd17: r = word_byte(32'(InfoSize), sel);
      6'd18, 6'd19, 6'd20, 6'd21: r = word_byte(32'(c.width), sel);
      6'd22, 6'd23, 6'd24, 6'd25: r = word_byte(neg_h, sel);
      6'd26:                     r = 8'd1;
      6'd28:                     r = 8'(BitCount);
      default:                   r = 8'd0;
    endcase
    return r;
  endfunction

  assign pos      = started_q ? pos_q : (cmd_i.hdr ? 6'd0 : 6'(HdrBytes));
  assign last_pos = 6'(HdrBytes + 2) + 6'(cmd_i.pad);
  assign is_last  = (pos == last_pos);
  assign advance  = cmd_valid_i && (!out_valid_q || pop_i);
  assign cmd_pop_o = advance && is_last;

  always_comb begin
    if (pos < 6'(HdrBytes)) begin
      cur_byte = hdr_byte(pos, cmd_i);
    end else if (pos == 6'(HdrBytes)) begin
      cur_byte = cmd_i.byte_b;
    end else if (pos == 6'(HdrBytes + 1)) begin
      cur_byte = cmd_i.byte_g;
    end else if (pos == 6'(HdrBytes + 2)) begin
      cur_byte = cmd_i.byte_r;
    end else begin
      cur_byte = 8'd0;
    end
  end

  assign empty_o  = !out_valid_q;
  assign result_o = out_q;

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q.out_byte    <= cur_byte;
      out_q.last_of_run <= is_last;
      out_q.frame_done  <= is_last && cmd_i.frame_end;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      started_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        out_valid_q <= 1'b1;
        started_q   <= !is_last;
        pos_q       <= pos + 6'd1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

### rtl/bmp_24bit_stream_encoder.sv
// Top level of the BMP stream encoder: pixels in, BMP file bytes out.
// Instantiates bse_front, bse_queue and bse_back; depends on bse_pkg.
//
//   Channel   Direction  Handshake          Payload
//   pixel     in         push_i / full_o    pixel_i  (red, green, blue)
//   result    out        empty_o / pop_i    result_o (out_byte, last_of_run, frame_done)
//   config    in         cfg_we_i           cfg_idx_i, cfg_data_i
//
// A pixel yields three bytes, fifty-seven when it opens a frame, and up to three
// more when it closes a row; the back sequencer emits one byte per cycle while
// pops keep up, which sets the rate. Reset clears the row and column counters
// and marks the header as pending; the size registers return to one. A stalled
// result port fills the command queue, and full_o then holds off new pixels.
module bmp_24bit_stream_encoder import bse_pkg::*; #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [SizeW-1:0] cfg_data_i,
  input  logic             push_i,
  output logic             full_o,
  input  pixel_t           pixel_i,
  output logic             empty_o,
  input  logic             pop_i,
  output result_t          result_o
);

  logic accept;
  cmd_t front_cmd, head_cmd;
  logic head_valid, head_pop;

  // A request is taken whenever the queue has room; the front updates its
  // counters in the same cycle and the classified command enters the queue.
  assign accept = push_i && !full_o;

  bse_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .accept_i   (accept),
    .pixel_i    (pixel_i),
    .cmd_o      (front_cmd)
  );

  // The queue decouples the two halves so a request can arrive while the
  // back is still spelling out the header or padding of an earlier one.
  bse_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (accept),
    .wr_data_i (front_cmd),
    .full_o    (full_o),
    .rd_i      (head_pop),
    .rd_data_o (head_cmd),
    .valid_o   (head_valid)
  );

  // The back holds the result in an output register and moves on as soon as
  // that register is free or being popped.
  bse_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (head_valid),
    .cmd_i       (head_cmd),
    .cmd_pop_o   (head_pop),
    .empty_o     (empty_o),
    .pop_i       (pop_i),
    .result_o    (result_o)
  );

endmodule

### sim/bse_checker.sv
// Checker for the BMP stream encoder: predicts the file bytes of every accepted
// pixel and compares them with the bytes popped from the result port.
// Depends on bse_pkg for the payload types, register indexes and header constants.
module bse_checker import bse_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [SizeW-1:0] cfg_data_i,
  input  logic             push_i,
  input  logic             full_o,
  input  pixel_t           pixel_i,
  input  logic             empty_o,
  input  logic             pop_i,
  input  result_t          result_o,
  output int               fail_count_o,
  output int               pending_bytes_o,
  output int               bytes_checked_o,
  output int               frames_closed_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [SizeW-1:0] width_q;
  logic [SizeW-1:0] height_q;
  logic [SizeW-1:0] column_q;
  logic [SizeW-1:0] row_q;
  logic             header_done_q;
  result_t          file_bytes[$];
  int               fails;
  int               checked;
  int               frames;

  function automatic logic [SizeW-1:0] clamp_side(input logic [SizeW-1:0] v);
    if (v == '0) return SizeW'(1);
    if (v > MaxSide) return SizeW'(MaxSide);
    return v;
  endfunction

  // Fixed point with 12 fraction bits, saturated to one byte.
  function automatic logic [7:0] channel_byte(input logic signed [15:0] c);
    if (c <= 0) return 8'h00;
    if (c >= 16'sd4096) return 8'hff;
    return c[11:4];
  endfunction

  task automatic queue_le(input logic [31:0] v, input int nbytes);
    result_t r;
    for (int i = 0; i < nbytes; i++) begin
      r.out_byte    = v[8*i +: 8];
      r.last_of_run = 1'b0;
      r.frame_done  = 1'b0;
      file_bytes.push_back(r);
    end
  endtask

  task automatic encode_pixel(input pixel_t p);
    logic [SizeW-1:0] w;
    logic [SizeW-1:0] h;
    int               pad;
    longint           fsize;
    logic             frame_end;
    result_t          tail;
    w = clamp_side(width_q);
    h = clamp_side(height_q);
    pad = (4 - (3 * int'(w)) % 4) % 4;
    frame_end = 1'b0;
    if (!header_done_q) begin
      fsize = 54 + (3 * longint'(w) + pad) * longint'(h);
      queue_le(32'(BmpMagic), 2);
      queue_le(32'(fsize), 4);
      queue_le(32'd0, 2);
      queue_le(32'd0, 2);
      queue_le(32'(HdrBytes), 4);
      queue_le(32'(InfoSize), 4);
      queue_le(32'(w), 4);
      queue_le(32'd0 - 32'(h), 4);
      queue_le(32'd1, 2);
      queue_le(32'(BitCount), 2);
      for (int i = 0; i < 6; i++) queue_le(32'd0, 4);
      header_done_q = 1'b1;
    end
    queue_le(32'(channel_byte(p.blue)), 1);
    queue_le(32'(channel_byte(p.green)), 1);
    queue_le(32'(channel_byte(p.red)), 1);
    if (column_q >= w - 1'b1) begin
      queue_le(32'd0, pad);
      column_q = '0;
      if (row_q >= h - 1'b1) begin
        frame_end     = 1'b1;
        row_q         = '0;
        header_done_q = 1'b0;
      end else begin
        row_q = row_q + 1'b1;
      end
    end else begin
      column_q = column_q + 1'b1;
    end
    tail = file_bytes.pop_back();
    tail.last_of_run = 1'b1;
    tail.frame_done  = frame_end;
    file_bytes.push_back(tail);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      width_q       = 1;
      height_q      = 1;
      column_q      = '0;
      row_q         = '0;
      header_done_q = 1'b0;
      file_bytes.delete();
    end else begin
      if (pop_i && !empty_o) begin
        if (file_bytes.size() == 0) begin
          $error("unexpected result byte %0h", result_o.out_byte);
          fails++;
        end else begin
          want = file_bytes.pop_front();
          if (result_o.out_byte !== want.out_byte) begin
            $error("out_byte: expected %0h, got %0h", want.out_byte, result_o.out_byte);
            fails++;
          end
          if (result_o.last_of_run !== want.last_of_run) begin
            $error("last_of_run: expected %0b, got %0b", want.last_of_run,
                   result_o.last_of_run);
            fails++;
          end
          if (result_o.frame_done !== want.frame_done) begin
            $error("frame_done: expected %0b, got %0b", want.frame_done,
                   result_o.frame_done);
            fails++;
          end
          if (want.frame_done) frames++;
          checked++;
        end
      end
      if (push_i && !full_o) encode_pixel(pixel_i);
      if (cfg_we_i) begin
        if (cfg_idx_i == CfgImageWidth) width_q = cfg_data_i;
        else if (cfg_idx_i == CfgImageHeight) height_q = cfg_data_i;
      end
    end
    fail_count_o    <= fails;
    pending_bytes_o <= file_bytes.size();
    bytes_checked_o <= checked;
    frames_closed_o <= frames;
  end

endmodule

### sim/tb_top.sv
// Top of the BMP stream encoder testbench: clock, reset, pixel and size stimulus,
// a randomly stalling byte sink and the verdict. Depends on bse_pkg, the encoder
// and bse_checker.
module tb_top;
  import bse_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // Generous timeout, well above a run with every pixel at its most bytes and the
  // sink stalling as long as it can before each byte.
  localparam int CycleLimit = 4000000;
  localparam int RandomPixels = 290;

  // Channel values around the saturation points: most negative, minus one, zero,
  // the smallest nonzero, the first value that reaches byte one, just below and
  // at full scale, and the largest positive value.
  localparam logic [15:0] CornerVals [12] = '{
    16'h8000, 16'hffff, 16'h0000, 16'h0001, 16'h000f, 16'h0010,
    16'h0ff0, 16'h0fff, 16'h1000, 16'h1001, 16'h7fff, 16'h0808
  };

  logic             clk_i      = 1'b0;
  logic             rst_ni     = 1'b0;
  logic             cfg_we_i   = 1'b0;
  logic             cfg_idx_i  = CfgImageWidth;
  logic [SizeW-1:0] cfg_data_i = '0;
  logic             push_i     = 1'b0;
  logic             full_o;
  pixel_t           pixel_i    = '0;
  logic             empty_o;
  logic             pop_i      = 1'b0;
  result_t          result_o;

  int fail_count;
  int pending_bytes;
  int bytes_checked;
  int frames_closed;

  int cycle_count  = 0;
  int pixels_sent  = 0;
  int settings_run = 0;
  int corner_idx   = 0;
  int pop_hold     = 0;
  int pop_roll;
  bit sender_eager = 1'b0;

  always #1 clk_i = ~clk_i;

  bmp_24bit_stream_encoder dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .push_i     (push_i),
    .full_o     (full_o),
    .pixel_i    (pixel_i),
    .empty_o    (empty_o),
    .pop_i      (pop_i),
    .result_o   (result_o)
  );

  bse_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .push_i          (push_i),
    .full_o          (full_o),
    .pixel_i         (pixel_i),
    .empty_o         (empty_o),
    .pop_i           (pop_i),
    .result_o        (result_o),
    .fail_count_o    (fail_count),
    .pending_bytes_o (pending_bytes),
    .bytes_checked_o (bytes_checked),
    .frames_closed_o (frames_closed)
  );

  // The watchdog stops a hung run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("bmp_24bit_stream_encoder regression: fail");
      $finish;
    end
  end

  // The byte sink alternates between bursts of pops and stalls. Most stalls are
  // short; now and then a long one lets the command queue fill up so that full_o
  // pushes back on the pixel side.
  always @(posedge clk_i) begin
    if (pop_hold == 0) begin
      pop_roll = $urandom_range(0, 99);
      if (pop_roll < 60) begin
        pop_i    <= 1'b1;
        pop_hold <= $urandom_range(0, 20);
      end else if (pop_roll < 92) begin
        pop_i    <= 1'b0;
        pop_hold <= $urandom_range(0, 3);
      end else begin
        pop_i    <= 1'b0;
        pop_hold <= $urandom_range(10, 50);
      end
    end else begin
      pop_hold <= pop_hold - 1;
    end
  end

  // Effective side length as the encoder sees it; used to size whole frames.
  function automatic int side_of(input logic [SizeW-1:0] v);
    if (v == '0) return 1;
    if (v > MaxSide) return int'(MaxSide);
    return int'(v);
  endfunction

  function automatic logic [15:0] random_channel();
    case ($urandom_range(0, 9))
      0, 1:    return 16'($urandom);
      2:       return CornerVals[$urandom_range(0, 11)];
      default: return 16'($urandom_range(0, 4200));
    endcase
  endfunction

  // Waits for the next edge so the checker's count covers the last accepted pixel,
  // then until every predicted byte has been popped, plus a short settle time.
  task automatic drain();
    @(posedge clk_i);
    while (pending_bytes != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic next_pixel(input bit directed, output pixel_t p);
    if (directed) begin
      // Walk the corner values with a different offset per channel, so every
      // channel sees every corner in a different combination.
      p.red      = CornerVals[corner_idx % 12];
      p.green    = CornerVals[(corner_idx + 5) % 12];
      p.blue     = CornerVals[(corner_idx + 9) % 12];
      corner_idx = corner_idx + 1;
    end else begin
      p.red   = random_channel();
      p.green = random_channel();
      p.blue  = random_channel();
    end
  endtask

  // Holds push_i high until the pixel is taken at an edge where full_o is low.
  task automatic send_pixel(input pixel_t p);
    pixel_i <= p;
    push_i  <= 1'b1;
    @(posedge clk_i);
    while (full_o) @(posedge clk_i);
    pixels_sent = pixels_sent + 1;
  endtask

  // Gap after an accepted pixel. Mostly none or short, sometimes long, and now
  // and then the sender holds off until the encoder has emptied completely.
  task automatic pause_sender(input bit directed);
    int roll;
    int gap;
    roll = $urandom_range(0, 99);
    gap  = 0;
    if (!directed && $urandom_range(0, 59) == 0) begin
      push_i <= 1'b0;
      drain();
    end else if (!sender_eager) begin
      if (roll < 50) gap = 0;
      else if (roll < 85) gap = $urandom_range(1, 3);
      else if (roll < 97) gap = $urandom_range(4, 10);
      else gap = $urandom_range(20, 60);
      if (gap > 0) begin
        push_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // One request train under one size setting. The sizes are only written with
  // the encoder idle; a train may stop mid-frame, so the next setting applies to
  // a partly written frame.
  task automatic run_phase(input logic [SizeW-1:0] w, input logic [SizeW-1:0] h,
                           input int count, input bit directed);
    pixel_t p;
    drain();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CfgImageWidth;
    cfg_data_i <= w;
    @(posedge clk_i);
    cfg_idx_i  <= CfgImageHeight;
    cfg_data_i <= h;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    settings_run = settings_run + 1;
    for (int i = 0; i < count; i++) begin
      next_pixel(directed, p);
      send_pixel(p);
      pause_sender(directed);
    end
    push_i <= 1'b0;
  endtask

  initial begin
    logic [SizeW-1:0] w;
    logic [SizeW-1:0] h;
    int               n;
    int               random_sent;
    random_sent = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. Zero sizes act as one, so the first frame is one pixel.
    run_phase(15'd0, 15'd0, 1, 1'b1);
    // Widths 1 to 4 give row padding of one, two, three and zero bytes.
    run_phase(15'd1, 15'd2, 2, 1'b1);
    run_phase(15'd2, 15'd1, 2, 1'b1);
    run_phase(15'd3, 15'd2, 6, 1'b1);
    run_phase(15'd4, 15'd1, 4, 1'b1);
    // Oversize sides clamp in the header; the frame is then closed early by
    // shrinking the sizes mid-frame.
    run_phase(15'h7fff, 15'h7fff, 2, 1'b1);
    run_phase(15'd1, 15'd1, 1, 1'b1);
    run_phase(15'(MaxSide), 15'd0, 2, 1'b1);
    run_phase(15'd1, 15'd1, 1, 1'b1);

    // Random part: mostly whole frames of small images with random colors,
    // some trains cut short mid-frame, and a few at the extreme sizes.
    while (random_sent < RandomPixels) begin
      if ($urandom_range(0, 7) == 0) begin
        case ($urandom_range(0, 3))
          0: begin w = 15'h7fff; h = 15'($urandom_range(0, 3)); end
          1: begin w = 15'(MaxSide); h = 15'($urandom_range(0, 3)); end
          2: begin w = 15'($urandom_range(1, 4)); h = 15'h7fff; end
          default: begin w = 15'($urandom); h = 15'($urandom); end
        endcase
        n = $urandom_range(1, 6);
      end else begin
        w = 15'($urandom_range(0, 7));
        h = 15'($urandom_range(0, 4));
        n = $urandom_range(1, 3) * side_of(w) * side_of(h);
        if ($urandom_range(0, 4) == 0) n = $urandom_range(1, side_of(w) * side_of(h));
      end
      if (n > RandomPixels - random_sent) n = RandomPixels - random_sent;
      sender_eager = ($urandom_range(0, 3) == 0);
      run_phase(w, h, n, 1'b0);
      random_sent = random_sent + n;
    end

    drain();
    repeat (30) @(posedge clk_i);
    $display("Sent %0d pixels under %0d size settings, zero and oversize sides included.",
             pixels_sent, settings_run);
    $display("Checked %0d file bytes, %0d frames closed.", bytes_checked, frames_closed);
    if (fail_count == 0 && pending_bytes == 0) begin
      $display("bmp_24bit_stream_encoder regression: pass");
    end else begin
      $display("bmp_24bit_stream_encoder regression: fail");
    end
    $finish;
  end

endmodule

### files.f
rtl/bse_pkg.sv
rtl/bse_front.sv
rtl/bse_queue.sv
rtl/bse_back.sv
rtl/bmp_24bit_stream_encoder.sv
sim/bse_checker.sv
sim/tb_top.sv
